// File: design/asa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package asa_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int SIZE_W      = OFFSET_BITS + 1;
  localparam int SHIFT_W     = 3;
  localparam int PCT_W       = 7;
  localparam int PROD_W      = OFFSET_BITS + PCT_W;
  localparam int CNT_W       = $clog2(PCT_W);
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [PCT_W-1:0]       PCT_SCALE   = PCT_W'(100);
  localparam logic [OFFSET_BITS-1:0] HEAP_RESET  = OFFSET_BITS'(4096);
  localparam logic [SHIFT_W-1:0]     SHIFT_RESET = SHIFT_W'(2);

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [SIZE_W-1:0]      size_t;
  typedef logic [SHIFT_W-1:0]     shift_t;
  typedef logic [PCT_W-1:0]       pct_t;
  typedef logic [PROD_W-1:0]      prod_t;

  typedef enum logic {
    REG_HEAP  = 1'b0,
    REG_ALIGN = 1'b1
  } reg_e;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_PUSH
  } state_e;

  typedef struct packed {
    off_t   heap_bytes;
    shift_t align_shift;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mul;
    logic div_step;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic grow;
  } dp_sts_t;

  // round up to 2^sh, zero takes one boundary; 17 bits so it never wraps
  function automatic size_t round_size(input off_t req, input shift_t sh);
    size_t mask;
    size_t sz;
    mask = (size_t'(1) << sh) - size_t'(1);
    sz   = (req == '0) ? size_t'(1) : size_t'(req);
    return (sz + mask) & ~mask;
  endfunction

endpackage
`default_nettype wire

// File: design/asa_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface asa_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  asa_pkg::off_t      request_bytes;

  modport source (output valid, output op, output request_bytes, input ready);
  modport sink   (input valid, input op, input request_bytes, output ready);
endinterface

interface asa_rsp_if;
  logic               valid;
  logic               ready;
  asa_pkg::off_t      block_offset;
  asa_pkg::off_t      granted_bytes;
  logic [1:0]         status;
  asa_pkg::pct_t      percent_used;

  modport source (output valid, output block_offset, output granted_bytes,
                  output status, output percent_used, input ready);
  modport sink   (input valid, input block_offset, input granted_bytes,
                  input status, input percent_used, output ready);
endinterface
`default_nettype wire

// File: design/asa_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module asa_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [asa_pkg::APB_AW-1:0] paddr,
  input  wire logic [asa_pkg::APB_DW-1:0] pwdata,
  output logic      [asa_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output asa_pkg::cfg_t                   cfg_o
);
  import asa_pkg::*;

  off_t   heap_q, heap_d;
  shift_t shift_q, shift_d;
  reg_e   sel;
  logic   wr;

  assign sel    = reg_e'(paddr[2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    heap_d  = heap_q;
    shift_d = shift_q;
    if (wr) begin
      case (sel)
        REG_HEAP:  heap_d  = pwdata[OFFSET_BITS-1:0];
        REG_ALIGN: shift_d = pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_HEAP:  prdata = APB_DW'(heap_q);
      REG_ALIGN: prdata = APB_DW'(shift_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q  <= HEAP_RESET;
      shift_q <= SHIFT_RESET;
    end else begin
      heap_q  <= heap_d;
      shift_q <= shift_d;
    end
  end

  assign cfg_o.heap_bytes  = heap_q;
  assign cfg_o.align_shift = shift_q;

endmodule
`default_nettype wire

// File: design/asa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module asa_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire asa_pkg::cfg_t     cfg_i,
  input  wire asa_pkg::dp_cmd_t  cmd_i,
  output asa_pkg::dp_sts_t       sts_o,
  input  wire logic              op_i,
  input  wire asa_pkg::off_t     request_bytes_i,
  output asa_pkg::off_t          block_offset_o,
  output asa_pkg::off_t          granted_bytes_o,
  output logic [1:0]             status_o,
  output asa_pkg::pct_t          percent_used_o
);
  import asa_pkg::*;

  // architectural state
  off_t    head_q, head_d;
  off_t    hw_q, hw_d;
  pct_t    pct_q, pct_d;

  // per-item working registers
  op_e     op_q;
  size_t   rnd_q;
  off_t    res_off_q, res_off_d;
  off_t    res_gnt_q, res_gnt_d;
  status_e res_st_q, res_st_d;
  prod_t   rem_q, rem_d;
  prod_t   dvs_q, dvs_d;

  // output register
  off_t    out_off_q, out_gnt_q;
  status_e out_st_q;
  pct_t    out_pct_q;

  size_t   sum;
  logic    fits;
  logic    rel_ok;
  size_t   diff;
  logic    ge;

  assign sum    = size_t'(head_q) + rnd_q;
  assign fits   = sum < size_t'(cfg_i.heap_bytes);
  assign diff   = size_t'(head_q) - rnd_q;
  assign rel_ok = rnd_q <= size_t'(head_q);
  assign ge     = rem_q >= dvs_q;

  assign sts_o.grow = (op_q == OP_ALLOC) && fits && (sum[OFFSET_BITS-1:0] > hw_q);

  always_comb begin
    head_d    = head_q;
    hw_d      = hw_q;
    pct_d     = pct_q;
    res_off_d = res_off_q;
    res_gnt_d = res_gnt_q;
    res_st_d  = res_st_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    if (cmd_i.exec) begin
      res_off_d = head_q;
      res_gnt_d = '0;
      if (op_q == OP_ALLOC) begin
        if (fits) begin
          head_d    = sum[OFFSET_BITS-1:0];
          res_gnt_d = rnd_q[OFFSET_BITS-1:0];
          res_st_d  = ST_OK;
          if (sts_o.grow) begin
            hw_d = sum[OFFSET_BITS-1:0];
          end
        end else begin
          res_st_d = ST_NO_ROOM;
        end
      end else begin
        if (rel_ok) begin
          head_d    = diff[OFFSET_BITS-1:0];
          res_off_d = diff[OFFSET_BITS-1:0];
          res_gnt_d = rnd_q[OFFSET_BITS-1:0];
          res_st_d  = ST_OK;
        end else begin
          res_st_d = ST_UNDERFLOW;
        end
      end
    end
    if (cmd_i.mul) begin
      rem_d = PROD_W'(hw_q) * PROD_W'(PCT_SCALE);
      dvs_d = PROD_W'(cfg_i.heap_bytes) << (PCT_W - 1);
      pct_d = '0;
    end
    // restoring division, one quotient bit per step, MSB first
    if (cmd_i.div_step) begin
      if (ge) begin
        rem_d = rem_q - dvs_q;
      end
      dvs_d = dvs_q >> 1;
      pct_d = {pct_q[PCT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      hw_q   <= '0;
      pct_q  <= '0;
    end else begin
      head_q <= head_d;
      hw_q   <= hw_d;
      pct_q  <= pct_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(op_i);
      rnd_q <= round_size(request_bytes_i, cfg_i.align_shift);
    end
    res_off_q <= res_off_d;
    res_gnt_q <= res_gnt_d;
    res_st_q  <= res_st_d;
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    if (cmd_i.push) begin
      out_off_q <= res_off_q;
      out_gnt_q <= res_gnt_q;
      out_st_q  <= res_st_q;
      out_pct_q <= pct_q;
    end
  end

  assign block_offset_o  = out_off_q;
  assign granted_bytes_o = out_gnt_q;
  assign status_o        = out_st_q;
  assign percent_used_o  = out_pct_q;

endmodule
`default_nettype wire

// File: design/asa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module asa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire asa_pkg::dp_sts_t  sts_i,
  output asa_pkg::dp_cmd_t       cmd_o
);
  import asa_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.grow ? S_MUL : S_PUSH;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = CNT_W'(PCT_W - 1);
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = (out_valid_q & ~out_ready_i) | cmd_o.push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: design/aligned_stack_allocator.sv
// channel   dir  handshake      payload
// in_if     in   valid/ready    op, request_bytes
// out_if    out  valid/ready    block_offset, granted_bytes, status, percent_used
// apb       in   psel/penable   paddr, pwdata, prdata (heap_bytes @0, align_shift @4)
//
// An item is accepted, executed and pushed when the high-water mark holds; when it rises,
// an x100 multiply and 7 restoring divide steps come between execute and push.
// One item is in flight at a time; the next is taken once the result is in the
// output register, which holds it while out_if.ready is low.
// Reset clears head, high-water mark and percent; registers return to 4096 and 2.
`timescale 1ns / 1ps
`default_nettype none
module aligned_stack_allocator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  asa_req_if.sink                         in_if,
  asa_rsp_if.source                       out_if,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [asa_pkg::APB_AW-1:0] paddr,
  input  wire logic [asa_pkg::APB_DW-1:0] pwdata,
  output logic      [asa_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import asa_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  asa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  asa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  asa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (in_if.op),
    .request_bytes_i (in_if.request_bytes),
    .block_offset_o  (out_if.block_offset),
    .granted_bytes_o (out_if.granted_bytes),
    .status_o        (out_if.status),
    .percent_used_o  (out_if.percent_used)
  );

endmodule
`default_nettype wire
